>>> hw/rtl/ebt_pkg.sv
`timescale 1ns / 1ps

package ebt_pkg;

  localparam int ENTRIES_DEF = 16;

  localparam int MODE_W = 3;
  localparam int BIT_W  = 16;
  localparam int TIME_W = 32;

  localparam logic [MODE_W-1:0] MODE_SET      = 3'd0;
  localparam logic [MODE_W-1:0] MODE_UNSET    = 3'd1;
  localparam logic [MODE_W-1:0] MODE_TOGGLE   = 3'd2;
  localparam logic [MODE_W-1:0] MODE_ISSET    = 3'd3;
  localparam logic [MODE_W-1:0] MODE_ISNOTSET = 3'd4;
  localparam logic [MODE_W-1:0] MODE_TIMEOUT  = 3'd5;

  typedef struct packed {
    logic start;
    logic scan;
    logic commit;
  } ctrl_cmd_t;

  typedef struct packed {
    logic scan_last;
    logic out_hold;
  } ctrl_sts_t;

endpackage

>>> hw/rtl/ebt_ctrl.sv
`timescale 1ns / 1ps

module ebt_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  ebt_pkg::ctrl_sts_t sts,
  output ebt_pkg::ctrl_cmd_t cmd
);

  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_SCAN   = 4'b0010,
    ST_DRAIN  = 4'b0100,
    ST_UPDATE = 4'b1000
  } state_t;

  state_t state_r;
  state_t state_nxt;

  assign in_stall = (state_r != ST_IDLE);

  always_comb begin
    state_nxt  = state_r;
    cmd.start  = 1'b0;
    cmd.scan   = 1'b0;
    cmd.commit = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.start = 1'b1;
          state_nxt = ST_SCAN;
        end
      end
      ST_SCAN: begin
        cmd.scan = 1'b1;
        if (sts.scan_last) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        state_nxt = ST_UPDATE;
      end
      ST_UPDATE: begin
        if (!sts.out_hold) begin
          cmd.commit = 1'b1;
          state_nxt  = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  a_scan_end: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SCAN && sts.scan_last) |=> (state_r == ST_DRAIN))
    else $error("scan did not end after last slot");

  a_no_commit_on_hold: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit |-> !sts.out_hold)
    else $error("commit while result register still held");

endmodule

>>> hw/rtl/ebt_dpath.sv
`timescale 1ns / 1ps

module ebt_dpath #(
  parameter int ENTRIES = ebt_pkg::ENTRIES_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic [ebt_pkg::MODE_W-1:0]  in_mode,
  input  logic [ebt_pkg::BIT_W-1:0]   in_bit_index,
  input  logic [ebt_pkg::TIME_W-1:0]  in_expire_time,
  input  logic [ebt_pkg::TIME_W-1:0]  in_now_time,
  input  ebt_pkg::ctrl_cmd_t          cmd,
  output ebt_pkg::ctrl_sts_t          sts,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic                        out_answer,
  output logic                        out_table_full
);

  localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CW = $clog2(ENTRIES + 1);

  // operands of the beat in flight
  logic [ebt_pkg::MODE_W-1:0] mode_r;
  logic [ebt_pkg::BIT_W-1:0]  id_r;
  logic [ebt_pkg::TIME_W-1:0] exp_in_r;
  logic [ebt_pkg::TIME_W-1:0] now_r;

  logic [CW-1:0]              cnt_r;
  logic [IW-1:0]              rd_addr;

  // entry storage
  logic [ENTRIES-1:0]         valid_r;
  logic [ebt_pkg::BIT_W-1:0]  idx_mem [ENTRIES];
  logic [ebt_pkg::TIME_W-1:0] exp_mem [ENTRIES];

  // read stage
  logic                       rd_pv_r;
  logic [IW-1:0]              rd_slot_r;
  logic                       rd_vbit_r;
  logic [ebt_pkg::BIT_W-1:0]  rd_idx_r;
  logic [ebt_pkg::TIME_W-1:0] rd_exp_r;

  // search results
  logic                       hit_r;
  logic [IW-1:0]              hit_slot_r;
  logic [ebt_pkg::TIME_W-1:0] hit_exp_r;
  logic                       free_r;
  logic [IW-1:0]              free_slot_r;
  logic                       late_r;

  logic                       out_valid_r;
  logic                       out_answer_r;
  logic                       out_full_r;

  logic                       upd_set;
  logic                       upd_clr;
  logic [IW-1:0]              upd_slot;
  logic                       answer_nxt;
  logic                       full_nxt;
  logic                       expired;

  assign rd_addr       = cnt_r[IW-1:0];
  assign sts.scan_last = (cnt_r == CW'(ENTRIES - 1));
  assign sts.out_hold  = out_valid_r && out_stall;

  assign out_valid      = out_valid_r;
  assign out_answer     = out_answer_r;
  assign out_table_full = out_full_r;

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      mode_r   <= in_mode;
      id_r     <= in_bit_index;
      exp_in_r <= in_expire_time;
      now_r    <= in_now_time;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r   <= '0;
      rd_pv_r <= 1'b0;
    end else begin
      rd_pv_r <= cmd.scan;
      if (cmd.start) begin
        cnt_r <= '0;
      end else if (cmd.scan) begin
        cnt_r <= cnt_r + CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.scan) begin
      rd_idx_r  <= idx_mem[rd_addr];
      rd_exp_r  <= exp_mem[rd_addr];
      rd_vbit_r <= valid_r[rd_addr];
      rd_slot_r <= rd_addr;
    end
    if (upd_set) begin
      idx_mem[upd_slot] <= id_r;
      exp_mem[upd_slot] <= exp_in_r;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      hit_r  <= 1'b0;
      free_r <= 1'b0;
      late_r <= 1'b0;
    end else if (rd_pv_r) begin
      if (rd_vbit_r && (rd_idx_r == id_r) && !hit_r) begin
        hit_r      <= 1'b1;
        hit_slot_r <= rd_slot_r;
        hit_exp_r  <= rd_exp_r;
      end
      if (!rd_vbit_r && !free_r) begin
        free_r      <= 1'b1;
        free_slot_r <= rd_slot_r;
      end
      if (rd_vbit_r && (rd_exp_r > now_r)) begin
        late_r <= 1'b1;
      end
    end
  end

  always_comb begin
    upd_set    = 1'b0;
    upd_clr    = 1'b0;
    upd_slot   = hit_slot_r;
    answer_nxt = 1'b0;
    full_nxt   = 1'b0;
    expired    = hit_r && (hit_exp_r < now_r);
    case (mode_r)
      ebt_pkg::MODE_SET, ebt_pkg::MODE_TOGGLE: begin
        if (hit_r) begin
          upd_clr = cmd.commit && (mode_r == ebt_pkg::MODE_TOGGLE);
        end else if (free_r) begin
          upd_set  = cmd.commit;
          upd_slot = free_slot_r;
        end else begin
          full_nxt = 1'b1;
        end
      end
      ebt_pkg::MODE_UNSET: begin
        upd_clr = cmd.commit && hit_r;
      end
      ebt_pkg::MODE_ISSET, ebt_pkg::MODE_ISNOTSET: begin
        upd_clr = cmd.commit && expired;
        if (mode_r == ebt_pkg::MODE_ISSET) begin
          answer_nxt = hit_r && !expired;
        end else begin
          answer_nxt = !(hit_r && !expired);
        end
      end
      ebt_pkg::MODE_TIMEOUT: begin
        answer_nxt = !late_r;
      end
      default: begin
        answer_nxt = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (upd_set) begin
      valid_r[upd_slot] <= 1'b1;
    end else if (upd_clr) begin
      valid_r[upd_slot] <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.commit) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      out_answer_r <= answer_nxt;
      out_full_r   <= full_nxt;
    end
  end

  a_commit_shows: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit |=> out_valid_r)
    else $error("result beat not presented after commit");

  a_full_no_answer: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_full_r) |-> !out_answer_r)
    else $error("dropped add carries an answer");

endmodule

>>> hw/rtl/expiring_bit_table_top.sv
`timescale 1ns / 1ps
// an accepted beat passes the scan, drain and update states; its result beat
// is registered on commit, which waits while out_stall holds the last result;
// the slot scan reads one table entry per cycle through a single memory port
// in_stall stays high while a beat is in flight or its result cannot be stored
// reset: synchronous active low, empties the table by clearing all valid bits

module expiring_bit_table_top #(
  parameter int ENTRIES = ebt_pkg::ENTRIES_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [ebt_pkg::MODE_W-1:0]  in_mode,
  input  logic [ebt_pkg::BIT_W-1:0]   in_bit_index,
  input  logic [ebt_pkg::TIME_W-1:0]  in_expire_time,
  input  logic [ebt_pkg::TIME_W-1:0]  in_now_time,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic                        out_answer,
  output logic                        out_table_full
);

  ebt_pkg::ctrl_cmd_t cmd;
  ebt_pkg::ctrl_sts_t sts;

  ebt_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  ebt_dpath #(
    .ENTRIES (ENTRIES)
  ) u_dpath (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_mode        (in_mode),
    .in_bit_index   (in_bit_index),
    .in_expire_time (in_expire_time),
    .in_now_time    (in_now_time),
    .cmd            (cmd),
    .sts            (sts),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_answer     (out_answer),
    .out_table_full (out_table_full)
  );

endmodule

>>> bench/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

  localparam int ENTRIES = ebt_pkg::ENTRIES_DEF;
  localparam logic [ebt_pkg::MODE_W-1:0] MODE_SPARE_LO = 3'd6;
  localparam logic [ebt_pkg::MODE_W-1:0] MODE_SPARE_HI = 3'd7;
  localparam int POOL_N = 20;

  typedef struct packed {
    logic [ebt_pkg::MODE_W-1:0] mode;
    logic [ebt_pkg::BIT_W-1:0]  bit_index;
    logic [ebt_pkg::TIME_W-1:0] expire_time;
    logic [ebt_pkg::TIME_W-1:0] now_time;
  } req_t;

  typedef struct packed {
    logic answer;
    logic table_full;
  } reply_t;

  logic                       clk;
  logic                       rst_n;
  logic                       in_valid;
  logic                       in_stall;
  logic [ebt_pkg::MODE_W-1:0] in_mode;
  logic [ebt_pkg::BIT_W-1:0]  in_bit_index;
  logic [ebt_pkg::TIME_W-1:0] in_expire_time;
  logic [ebt_pkg::TIME_W-1:0] in_now_time;
  logic                       out_valid;
  logic                       out_stall;
  logic                       out_answer;
  logic                       out_table_full;

  expiring_bit_table_top #(.ENTRIES(ENTRIES)) dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_mode(in_mode),
    .in_bit_index(in_bit_index),
    .in_expire_time(in_expire_time),
    .in_now_time(in_now_time),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_answer(out_answer),
    .out_table_full(out_table_full)
  );

  // shadow copy of the bit table
  logic                       tbl_valid [ENTRIES];
  logic [ebt_pkg::BIT_W-1:0]  tbl_index [ENTRIES];
  logic [ebt_pkg::TIME_W-1:0] tbl_expiry [ENTRIES];

  req_t   req_q[$];
  reply_t reply_q[$];
  req_t   cur_req;
  reply_t drv_reply;
  reply_t mon_reply;

  logic [ebt_pkg::BIT_W-1:0]  id_pool [POOL_N];
  logic [ebt_pkg::TIME_W-1:0] t_base;

  int   phase;
  int   send_idle_pct;
  int   recv_stall_pct;
  logic long_hold;
  int   fail_count;

  task automatic apply_request(input req_t r, output reply_t y);
    int   i;
    int   hit;
    int   free_slot;
    logic present;
    logic do_add;
    hit = -1;
    free_slot = -1;
    present = 1'b0;
    do_add = 1'b0;
    y = '0;
    for (i = ENTRIES - 1; i >= 0; i--) begin
      if (tbl_valid[i] && tbl_index[i] == r.bit_index) hit = i;
      if (!tbl_valid[i]) free_slot = i;
    end
    case (r.mode)
      ebt_pkg::MODE_SET: begin
        if (hit < 0) do_add = 1'b1;
      end
      ebt_pkg::MODE_UNSET: begin
        if (hit >= 0) tbl_valid[hit] = 1'b0;
      end
      ebt_pkg::MODE_TOGGLE: begin
        if (hit >= 0) tbl_valid[hit] = 1'b0;
        else do_add = 1'b1;
      end
      ebt_pkg::MODE_ISSET, ebt_pkg::MODE_ISNOTSET: begin
        if (hit >= 0) begin
          if (tbl_expiry[hit] < r.now_time) tbl_valid[hit] = 1'b0;
          else present = 1'b1;
        end
        y.answer = (r.mode == ebt_pkg::MODE_ISSET) ? present : !present;
      end
      ebt_pkg::MODE_TIMEOUT: begin
        y.answer = 1'b1;
        for (i = 0; i < ENTRIES; i++) begin
          if (tbl_valid[i] && tbl_expiry[i] > r.now_time) y.answer = 1'b0;
        end
      end
      default: begin
      end
    endcase
    if (do_add) begin
      if (free_slot < 0) begin
        y.table_full = 1'b1;
      end else begin
        tbl_valid[free_slot] = 1'b1;
        tbl_index[free_slot] = r.bit_index;
        tbl_expiry[free_slot] = r.expire_time;
      end
    end
  endtask

  task automatic push_req(input logic [ebt_pkg::MODE_W-1:0] m,
                          input logic [ebt_pkg::BIT_W-1:0] id,
                          input logic [ebt_pkg::TIME_W-1:0] ex,
                          input logic [ebt_pkg::TIME_W-1:0] nw);
    req_t r;
    r.mode = m;
    r.bit_index = id;
    r.expire_time = ex;
    r.now_time = nw;
    req_q.push_back(r);
  endtask

  task automatic queue_random(input int n);
    int                         k;
    int                         roll;
    logic [31:0]                rnd;
    logic [ebt_pkg::MODE_W-1:0] m;
    for (k = 0; k < POOL_N; k++) begin
      rnd = $urandom;
      id_pool[k] = rnd[ebt_pkg::BIT_W-1:0];
    end
    id_pool[0] = '0;
    id_pool[1] = '1;
    t_base = $urandom;
    for (k = 0; k < n; k++) begin
      roll = $urandom_range(99);
      if (roll < 30) m = ebt_pkg::MODE_SET;
      else if (roll < 42) m = ebt_pkg::MODE_UNSET;
      else if (roll < 57) m = ebt_pkg::MODE_TOGGLE;
      else if (roll < 72) m = ebt_pkg::MODE_ISSET;
      else if (roll < 86) m = ebt_pkg::MODE_ISNOTSET;
      else if (roll < 96) m = ebt_pkg::MODE_TIMEOUT;
      else if (roll < 98) m = MODE_SPARE_LO;
      else m = MODE_SPARE_HI;
      if ($urandom_range(19) == 0) begin
        rnd = $urandom;
        push_req(m, rnd[ebt_pkg::BIT_W-1:0], $urandom, $urandom);
      end else begin
        push_req(m, id_pool[$urandom_range(POOL_N - 1)], t_base + $urandom_range(40),
                 t_base + $urandom_range(50));
      end
      t_base = t_base + $urandom_range(2);
    end
  endtask

  task automatic wait_drained();
    while (!(req_q.size() == 0 && !in_valid && reply_q.size() == 0)) @(posedge clk);
  endtask

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        apply_request(cur_req, drv_reply);
        reply_q.push_back(drv_reply);
      end
      if (!in_valid || !in_stall) begin
        if (req_q.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          cur_req = req_q.pop_front();
          in_valid <= 1'b1;
          in_mode <= cur_req.mode;
          in_bit_index <= cur_req.bit_index;
          in_expire_time <= cur_req.expire_time;
          in_now_time <= cur_req.now_time;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (reply_q.size() == 0) begin
          $display("%0t: unexpected result beat, answer %0b table_full %0b",
                   $time, out_answer, out_table_full);
          fail_count++;
        end else begin
          mon_reply = reply_q.pop_front();
          if (out_answer !== mon_reply.answer) begin
            $display("%0t: answer expected %0b actual %0b", $time, mon_reply.answer,
                     out_answer);
            fail_count++;
          end
          if (out_table_full !== mon_reply.table_full) begin
            $display("%0t: table_full expected %0b actual %0b", $time,
                     mon_reply.table_full, out_table_full);
            fail_count++;
          end
        end
      end
      out_stall <= long_hold || ($urandom_range(99) < recv_stall_pct);
    end
  end

  // long receiver hold-off so the block backs up into its input
  initial begin
    long_hold = 1'b0;
    wait (phase == 1);
    repeat (40) @(posedge clk);
    long_hold <= 1'b1;
    repeat (400) @(posedge clk);
    long_hold <= 1'b0;
  end

  initial begin
    #2_000_000;
    $display("FAIL expiring_bit_table_top");
    $finish;
  end

  initial begin
    int i;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_mode = '0;
    in_bit_index = '0;
    in_expire_time = '0;
    in_now_time = '0;
    out_stall = 1'b0;
    phase = 0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    fail_count = 0;
    for (i = 0; i < ENTRIES; i++) begin
      tbl_valid[i] = 1'b0;
      tbl_index[i] = '0;
      tbl_expiry[i] = '0;
    end

    // empty table, equal expiry, kept expiry, full table, expiry removal
    push_req(ebt_pkg::MODE_TIMEOUT, 16'h0000, 32'd0, 32'd0);
    push_req(ebt_pkg::MODE_UNSET, 16'hFFFF, 32'd0, 32'd0);
    push_req(ebt_pkg::MODE_SET, 16'h0000, 32'd100, 32'd0);
    push_req(ebt_pkg::MODE_SET, 16'h0000, 32'd5, 32'd0);
    push_req(ebt_pkg::MODE_ISSET, 16'h0000, 32'd0, 32'd100);
    push_req(ebt_pkg::MODE_TIMEOUT, 16'h0000, 32'd0, 32'd99);
    push_req(ebt_pkg::MODE_TIMEOUT, 16'h0000, 32'd0, 32'd100);
    push_req(ebt_pkg::MODE_TOGGLE, 16'hFFFF, 32'hFFFF_FFFF, 32'd0);
    for (i = 1; i <= ENTRIES - 2; i++)
      push_req(ebt_pkg::MODE_SET, i[ebt_pkg::BIT_W-1:0], i * 1000, 32'd0);
    push_req(ebt_pkg::MODE_SET, 16'h8000, 32'd7, 32'd0);
    push_req(ebt_pkg::MODE_TOGGLE, 16'h7FFF, 32'd9, 32'd0);
    push_req(ebt_pkg::MODE_ISNOTSET, 16'h0000, 32'd0, 32'd101);
    push_req(ebt_pkg::MODE_TOGGLE, 16'hFFFF, 32'd0, 32'hFFFF_FFFF);
    push_req(MODE_SPARE_HI, 16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    wait_drained();

    for (i = 1; i <= 4; i++) begin
      phase <= i;
      send_idle_pct <= (i == 2) ? 60 : (i == 4) ? 16 : 0;
      recv_stall_pct <= (i == 3) ? 60 : (i == 4) ? 16 : 0;
      queue_random(150);
      wait_drained();
    end

    repeat (40) @(posedge clk);
    if (fail_count == 0)
      $display("PASS expiring_bit_table_top");
    else
      $display("FAIL expiring_bit_table_top");
    $finish;
  end

endmodule

>>> expiring_bit_table_top.f
hw/rtl/ebt_pkg.sv
hw/rtl/ebt_ctrl.sv
hw/rtl/ebt_dpath.sv
hw/rtl/expiring_bit_table_top.sv
bench/tb_top.sv
